[rtl/lidar_frame_parser_assert.svh]
// Assertion macros used by the parser's top-level RTL.
// Both macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef LIDAR_FRAME_PARSER_ASSERT_SVH
`define LIDAR_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define LFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lidar_frame_parser: same-cycle check failed");

// Next-cycle implication.
`define LFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lidar_frame_parser: next-cycle check failed");

`endif

[rtl/lfp_pkg.sv]
`timescale 1ns / 1ps

package lfp_pkg;

	localparam int POINTS_PER_FRAME_DEF = 16;

	// APB register file
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [1:0] REG_LENGTH_CODE   = 2'd2;

	// Fixed byte positions at the head of a frame
	localparam int POS_HDR0     = 0;
	localparam int POS_HDR1     = 1;
	localparam int POS_LEN      = 2;
	localparam int POS_SPEED_HI = 3;
	localparam int POS_SPEED_LO = 4;
	localparam int POS_START_HI = 5;
	localparam int POS_START_LO = 6;
	localparam int POS_POINTS   = 7;

	// Byte of a point being received
	localparam logic [1:0] PART_DIST_HI  = 2'd0;
	localparam logic [1:0] PART_DIST_LO  = 2'd1;
	localparam logic [1:0] PART_STRENGTH = 2'd2;

	// Result item layout
	localparam int OUT_TDATA_W = 80;

	typedef struct packed {
		logic [7:0] first_header;
		logic [7:0] second_header;
		logic [7:0] length_code;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_FAIL,
		ST_READ,
		ST_EMIT
	} ctrl_st_t;

	typedef struct packed {
		logic byte_en;
		logic rd_clr;
		logic rd_en;
		logic rd_inc;
		logic out_load_pt;
		logic out_load_fail;
	} dp_cmd_t;

	typedef struct packed {
		logic at_check;
		logic sum_match;
		logic pt_last;
	} dp_stat_t;

endpackage

[rtl/lfp_regs.sv]
`timescale 1ns / 1ps

module lfp_regs import lfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FIRST_HEADER:  cfg_q.first_header  <= pwdata[7:0];
				REG_SECOND_HEADER: cfg_q.second_header <= pwdata[7:0];
				REG_LENGTH_CODE:   cfg_q.length_code   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_FIRST_HEADER:  prdata[7:0] = cfg_q.first_header;
			REG_SECOND_HEADER: prdata[7:0] = cfg_q.second_header;
			REG_LENGTH_CODE:   prdata[7:0] = cfg_q.length_code;
			default:           prdata      = '0;
		endcase
	end

endmodule

[rtl/lfp_dp.sv]
`timescale 1ns / 1ps

module lfp_dp import lfp_pkg::*; #(
	parameter int POINTS_PER_FRAME = POINTS_PER_FRAME_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic [7:0]             rx_byte,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_ok,
	output logic                   out_last
);

	localparam int POS_W = $clog2(3 * POINTS_PER_FRAME + 10);
	localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
	localparam logic [POS_W-1:0] P_END_HI = POS_W'(3 * POINTS_PER_FRAME + 7);
	localparam logic [POS_W-1:0] P_END_LO = POS_W'(3 * POINTS_PER_FRAME + 8);
	localparam logic [POS_W-1:0] P_CHECK  = POS_W'(3 * POINTS_PER_FRAME + 9);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS_PER_FRAME - 1);

	// Parser control state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [1:0]       part_q;
	logic [IDX_W-1:0] widx_q;
	logic [IDX_W-1:0] rd_q;

	// Frame payload
	logic [15:0] speed_q;
	logic [15:0] start_q;
	logic [15:0] end_q;
	logic [7:0]  dhi_q;
	logic [7:0]  dlo_q;
	logic [23:0] mem [POINTS_PER_FRAME];
	logic [23:0] rd_data_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic out_ok_q;
	logic out_last_q;

	logic restart;
	logic in_points;
	logic [IDX_W+3:0] idx_ext;

	assign stat.at_check  = (pos_q == P_CHECK);
	assign stat.sum_match = (rx_byte == sum_q);
	assign stat.pt_last   = (rd_q == IDX_LAST);

	assign in_points = (pos_q >= POS_W'(POS_POINTS)) && (pos_q < P_END_HI);
	assign restart = ((pos_q == POS_W'(POS_HDR0)) && (rx_byte != cfg.first_header))
		|| ((pos_q == POS_W'(POS_HDR1)) && (rx_byte != cfg.second_header))
		|| ((pos_q == POS_W'(POS_LEN)) && (rx_byte != cfg.length_code))
		|| stat.at_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			part_q <= PART_DIST_HI;
			widx_q <= '0;
		end else if (cmd.byte_en) begin
			if (restart) begin
				pos_q  <= '0;
				sum_q  <= '0;
				part_q <= PART_DIST_HI;
				widx_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_q + rx_byte;
				if (in_points) begin
					case (part_q)
						PART_DIST_HI: part_q <= PART_DIST_LO;
						PART_DIST_LO: part_q <= PART_STRENGTH;
						default: begin
							part_q <= PART_DIST_HI;
							widx_q <= (widx_q == IDX_LAST) ? '0 : widx_q + 1'b1;
						end
					endcase
				end
			end
		end
	end

	// Field assembly, high byte first.
	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			case (pos_q)
				POS_W'(POS_SPEED_HI): speed_q[15:8] <= rx_byte;
				POS_W'(POS_SPEED_LO): speed_q[7:0]  <= rx_byte;
				POS_W'(POS_START_HI): start_q[15:8] <= rx_byte;
				POS_W'(POS_START_LO): start_q[7:0]  <= rx_byte;
				P_END_HI:             end_q[15:8]   <= rx_byte;
				P_END_LO:             end_q[7:0]    <= rx_byte;
				default: ;
			endcase
			if (in_points && (part_q == PART_DIST_HI)) begin
				dhi_q <= rx_byte;
			end
			if (in_points && (part_q == PART_DIST_LO)) begin
				dlo_q <= rx_byte;
			end
		end
	end

	// Point store: one whole entry is written on the strength byte.
	always_ff @(posedge clk) begin
		if (cmd.byte_en && in_points && (part_q == PART_STRENGTH)) begin
			mem[widx_q] <= {dhi_q, dlo_q, rx_byte};
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (cmd.rd_clr) begin
			rd_q <= '0;
		end else if (cmd.rd_inc) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	assign idx_ext = {4'b0000, rd_q};

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load_fail) begin
			out_data_q <= '0;
			out_ok_q   <= 1'b0;
			out_last_q <= 1'b1;
		end else if (cmd.out_load_pt) begin
			out_data_q <= {4'b0000, rd_data_q[7:0], rd_data_q[23:8], idx_ext[3:0],
				end_q, start_q, speed_q};
			out_ok_q   <= 1'b1;
			out_last_q <= stat.pt_last;
		end
	end

	assign out_data = out_data_q;
	assign out_ok   = out_ok_q;
	assign out_last = out_last_q;

endmodule

[rtl/lfp_ctrl.sv]
`timescale 1ns / 1ps

module lfp_ctrl import lfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_st_t st_q, st_d;
	logic     out_valid_q;
	logic     slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RECV;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load_pt || cmd.out_load_fail) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (st_q)
			ST_RECV: begin
				in_ready    = 1'b1;
				cmd.byte_en = in_valid;
				if (in_valid && stat.at_check) begin
					if (stat.sum_match) begin
						cmd.rd_clr = 1'b1;
						st_d       = ST_READ;
					end else begin
						st_d = ST_FAIL;
					end
				end
			end
			ST_FAIL: begin
				if (slot_free) begin
					cmd.out_load_fail = 1'b1;
					st_d              = ST_RECV;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				st_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.out_load_pt = 1'b1;
					if (stat.pt_last) begin
						st_d = ST_RECV;
					end else begin
						cmd.rd_inc = 1'b1;
						st_d       = ST_READ;
					end
				end
			end
			default: st_d = ST_RECV;
		endcase
	end

endmodule

[rtl/lidar_frame_parser.sv]
`timescale 1ns / 1ps
`include "lidar_frame_parser_assert.svh"

// Lidar frame parser. Each input item is one received byte; the block walks a
// frame of two header bytes, a length byte, speed, start angle,
// POINTS_PER_FRAME points of distance (high, low) and strength, end angle and
// a checksum byte. The three fixed bytes are compared with the APB registers
// first_header (0x0), second_header (0x4) and length_code (0x8); a mismatch
// drops the byte and restarts the search at the first header byte. When the
// checksum byte equals the 8-bit sum of all earlier frame bytes the block
// sends one result item per point, the last one with tlast set; otherwise it
// sends a single item with frame_ok clear, tlast set and all data zero.
// While receiving, the block keeps s_tready high, also while a result item is
// still waiting at the output. The checksum byte of a good frame is followed,
// for each point, by a read of the point memory and then a load of the output
// register; no byte is taken until the last point is loaded, and each load
// waits while the output side stalls. A bad frame loads its zeroed item, also
// waiting for room at the output, before the next byte is taken. Configuration
// is meant to be written only while the block is idle.

module lidar_frame_parser import lfp_pkg::*; #(
	parameter int POINTS_PER_FRAME = POINTS_PER_FRAME_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// Byte stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] rx_byte

	// Point results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [15:0] speed, [31:16] start_angle, [47:32] end_angle, [51:48] point_index,
	// [67:52] distance, [75:68] strength, [79:76] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]             m_tuser,   // [0] frame_ok
	output logic                   m_tlast,   // last result of the frame

	// Configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     out_ok;

	lfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller sequences byte intake and the result burst; the datapath
	// holds the parse position, running sum, frame fields and point memory.
	lfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfp_dp #(
		.POINTS_PER_FRAME (POINTS_PER_FRAME)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (m_tdata),
		.out_ok   (out_ok),
		.out_last (m_tlast)
	);

	assign m_tuser[0] = out_ok;

	// No byte is taken while the point memory is being read out.
	`LFP_ASSERT_IMP(a_no_intake_in_burst, cmd.rd_en || cmd.out_load_pt, !s_tready)
	// The output register is only loaded when it is empty or being emptied.
	`LFP_ASSERT_IMP(a_load_has_room, cmd.out_load_pt || cmd.out_load_fail, !m_tvalid || m_tready)
	// A failed frame is a single zeroed item that closes the frame.
	`LFP_ASSERT_IMP(a_fail_item_zero, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0))
	// A loaded result is presented in the following cycle.
	`LFP_ASSERT_NEXT(a_load_shows, cmd.out_load_pt || cmd.out_load_fail, m_tvalid)

endmodule

[dv/lidar_frame_parser_checker.sv]
`timescale 1ns / 1ps

module lidar_frame_parser_checker import lfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [7:0]             s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [0:0]             m_tuser,
	input  logic                   m_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	input  logic [APB_DW-1:0]      prdata,
	input  logic                   pready,
	output int                     fail_count,
	output int                     points_due
);

	localparam int NPTS       = POINTS_PER_FRAME_DEF;
	localparam int POS_END_HI = POS_POINTS + 3 * NPTS;
	localparam int POS_END_LO = POS_END_HI + 1;

	typedef struct packed {
		logic [15:0] speed;
		logic [15:0] start_angle;
		logic [15:0] end_angle;
		logic [3:0]  point_index;
		logic [15:0] distance;
		logic [7:0]  strength;
		logic        frame_ok;
		logic        is_last;
	} point_result_t;

	cfg_t          cfg;
	int            frame_pos;
	logic [7:0]    byte_sum;
	logic [15:0]   speed_hold;
	logic [15:0]   start_hold;
	logic [15:0]   end_hold;
	logic [23:0]   point_mem [NPTS];
	point_result_t expected_points [$];

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			report(what, want, got);
		end
	endtask

	task automatic take_byte(input logic [7:0] b);
		byte_sum = byte_sum + b;
		frame_pos++;
	endtask

	task automatic restart_frame();
		frame_pos = 0;
		byte_sum  = 8'h00;
	endtask

	// Advances the frame walk by one byte and queues the point results that a
	// checksum byte releases.
	task automatic parse_byte(input logic [7:0] b);
		int            off;
		logic [1:0]    part;
		point_result_t r;
		if (frame_pos == POS_HDR0) begin
			if (b == cfg.first_header) take_byte(b); else restart_frame();
		end else if (frame_pos == POS_HDR1) begin
			if (b == cfg.second_header) take_byte(b); else restart_frame();
		end else if (frame_pos == POS_LEN) begin
			if (b == cfg.length_code) take_byte(b); else restart_frame();
		end else if (frame_pos == POS_SPEED_HI) begin
			speed_hold[15:8] = b;
			take_byte(b);
		end else if (frame_pos == POS_SPEED_LO) begin
			speed_hold[7:0] = b;
			take_byte(b);
		end else if (frame_pos == POS_START_HI) begin
			start_hold[15:8] = b;
			take_byte(b);
		end else if (frame_pos == POS_START_LO) begin
			start_hold[7:0] = b;
			take_byte(b);
		end else if (frame_pos < POS_END_HI) begin
			off  = frame_pos - POS_POINTS;
			part = 2'(off % 3);
			case (part)
				PART_DIST_HI:  point_mem[off / 3][23:16] = b;
				PART_DIST_LO:  point_mem[off / 3][15:8]  = b;
				PART_STRENGTH: point_mem[off / 3][7:0]   = b;
				default: ;
			endcase
			take_byte(b);
		end else if (frame_pos == POS_END_HI) begin
			end_hold[15:8] = b;
			take_byte(b);
		end else if (frame_pos == POS_END_LO) begin
			end_hold[7:0] = b;
			take_byte(b);
		end else begin
			if (b == byte_sum) begin
				for (int k = 0; k < NPTS; k++) begin
					r.speed       = speed_hold;
					r.start_angle = start_hold;
					r.end_angle   = end_hold;
					r.point_index = 4'(k);
					r.distance    = point_mem[k][23:8];
					r.strength    = point_mem[k][7:0];
					r.frame_ok    = 1'b1;
					r.is_last     = (k == NPTS - 1);
					expected_points.push_back(r);
				end
			end else begin
				// A failed checksum zeroes the held fields as well as the result.
				r         = '0;
				r.is_last = 1'b1;
				expected_points.push_back(r);
				speed_hold = '0;
				start_hold = '0;
				end_hold   = '0;
				for (int k = 0; k < NPTS; k++) point_mem[k] = '0;
			end
			restart_frame();
		end
	endtask

	task automatic check_point();
		point_result_t want;
		if (expected_points.size() == 0) begin
			report("unexpected result item", 16'h0, m_tdata[15:0]);
		end else begin
			want = expected_points.pop_front();
			check_field("speed",       want.speed,       m_tdata[15:0]);
			check_field("start_angle", want.start_angle, m_tdata[31:16]);
			check_field("end_angle",   want.end_angle,   m_tdata[47:32]);
			check_field("point_index", 16'(want.point_index), 16'(m_tdata[51:48]));
			check_field("distance",    want.distance,    m_tdata[67:52]);
			check_field("strength",    16'(want.strength), 16'(m_tdata[75:68]));
			check_field("tdata pad",   16'h0,            16'(m_tdata[79:76]));
			check_field("frame_ok",    16'(want.frame_ok), 16'(m_tuser[0]));
			check_field("tlast",       16'(want.is_last),  16'(m_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			cfg        = '0;
			speed_hold = '0;
			start_hold = '0;
			end_hold   = '0;
			for (int k = 0; k < NPTS; k++) point_mem[k] = '0;
			restart_frame();
			expected_points.delete();
		end else begin
			if (m_tvalid && m_tready) check_point();
			if (s_tvalid && s_tready) parse_byte(s_tdata);
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[APB_AW-1:2])
						REG_FIRST_HEADER:  cfg.first_header  = pwdata[7:0];
						REG_SECOND_HEADER: cfg.second_header = pwdata[7:0];
						REG_LENGTH_CODE:   cfg.length_code   = pwdata[7:0];
						default: ;
					endcase
				end else begin
					case (paddr[APB_AW-1:2])
						REG_FIRST_HEADER:
							check_field("first_header read", 16'(cfg.first_header),
								16'(prdata[7:0]));
						REG_SECOND_HEADER:
							check_field("second_header read", 16'(cfg.second_header),
								16'(prdata[7:0]));
						REG_LENGTH_CODE:
							check_field("length_code read", 16'(cfg.length_code),
								16'(prdata[7:0]));
						default: ;
					endcase
				end
			end
		end
		points_due = expected_points.size();
	end

endmodule

[dv/lidar_frame_parser_tb.sv]
`timescale 1ns / 1ps

module lidar_frame_parser_tb;
	import lfp_pkg::*;

	localparam int NPTS          = POINTS_PER_FRAME_DEF;
	// Header, length, speed and start angle, the points, end angle and checksum.
	localparam int FRAME_BYTES   = POS_POINTS + 3 * NPTS + 3;
	// Settling time sized to cover the point burst after a good checksum.
	localparam int DRAIN_CYCLES  = 2 * NPTS + 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 50;

	// Ways of filling the body of a frame.
	localparam int FILL_ZERO   = 0;
	localparam int FILL_ONES   = 1;
	localparam int FILL_RANDOM = 2;

	// An address above the three registers; writes there must change nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;    // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [15:0] speed, [31:16] start_angle, [47:32] end_angle, [51:48] point_index,
	// [67:52] distance, [75:68] strength, [79:76] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;    // [0] frame_ok
	logic                   m_tlast;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	int   fail_count;
	int   points_due;

	// Percent of cycles in which the byte source and the result sink hold off.
	int   send_idle_pct;
	int   recv_idle_pct;
	int   sent_items;
	int   quiet_cycles = 0;
	// Copy of the header registers, used to build frames that the parser locks onto.
	cfg_t cur_cfg;

	lidar_frame_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lidar_frame_parser_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.points_due (points_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result sink decides at each falling edge whether it takes an item in
	// the coming cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a run that stops moving items or register accesses is a hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one byte, with a random hold-off first, and returns at the falling
	// edge after it was taken. tvalid stays high so that back-to-back bytes
	// need no second assignment in one time step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	// Stops sending until every predicted result has come out, then lets the
	// block settle for as long as a full point burst takes.
	task automatic drain_block();
		s_tvalid = 1'b0;
		while (points_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One APB transfer: a setup cycle, then an access cycle held until pready.
	task automatic apb_access(input logic wr, input logic [1:0] index, input logic [31:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {index, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Writes the three header registers with junk in the unused upper bits,
	// pokes the unused address, then reads the three registers back for the checker.
	task automatic set_config(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] len);
		drain_block();
		apb_access(1'b1, REG_FIRST_HEADER,  {24'($urandom()), h0});
		apb_access(1'b1, REG_SECOND_HEADER, {24'($urandom()), h1});
		apb_access(1'b1, REG_LENGTH_CODE,   {24'($urandom()), len});
		apb_access(1'b1, REG_UNUSED,        $urandom());
		cur_cfg = '{first_header: h0, second_header: h1, length_code: len};
		apb_access(1'b0, REG_FIRST_HEADER,  '0);
		apb_access(1'b0, REG_SECOND_HEADER, '0);
		apb_access(1'b0, REG_LENGTH_CODE,   '0);
	endtask

	// Sends a complete frame with the current headers. The checksum is the
	// true byte sum, or that sum plus a nonzero offset for a corrupted frame.
	task automatic send_frame(input int fill, input bit sum_ok);
		logic [7:0] frame_bytes [FRAME_BYTES];
		logic [7:0] sum;
		sum = 8'h00;
		frame_bytes[POS_HDR0] = cur_cfg.first_header;
		frame_bytes[POS_HDR1] = cur_cfg.second_header;
		frame_bytes[POS_LEN]  = cur_cfg.length_code;
		for (int k = POS_SPEED_HI; k < FRAME_BYTES - 1; k++) begin
			if (fill == FILL_ZERO) begin
				frame_bytes[k] = 8'h00;
			end else if (fill == FILL_ONES) begin
				frame_bytes[k] = 8'hFF;
			end else begin
				// Random body with extreme bytes mixed in.
				case ($urandom_range(7))
					0: frame_bytes[k] = 8'h00;
					1: frame_bytes[k] = 8'hFF;
					default: frame_bytes[k] = 8'($urandom());
				endcase
			end
		end
		for (int k = 0; k < FRAME_BYTES - 1; k++) sum = sum + frame_bytes[k];
		frame_bytes[FRAME_BYTES-1] = sum_ok ? sum : sum + 8'($urandom_range(1, 255));
		for (int k = 0; k < FRAME_BYTES; k++) send_byte(frame_bytes[k]);
	endtask

	// Returns a byte that differs from the one the parser expects.
	function automatic logic [7:0] other_byte(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom());
		if (b == avoid) b = b + 8'd1;
		return b;
	endfunction

	// One stretch of random traffic. Most of it is well-formed frames with
	// random content, so that the parser gets past the fixed bytes; the rest
	// is corrupted checksums, headers broken after one or two bytes, and line
	// noise that never matches the first header byte and so leaves the parser
	// waiting at the start of a frame.
	task automatic random_segment();
		int roll;
		int n;
		roll = $urandom_range(99);
		if (roll < 60) begin
			send_frame(FILL_RANDOM, 1'b1);
		end else if (roll < 75) begin
			send_frame(FILL_RANDOM, 1'b0);
		end else if (roll < 88) begin
			send_byte(cur_cfg.first_header);
			if ($urandom_range(1)) begin
				send_byte(cur_cfg.second_header);
				send_byte(other_byte(cur_cfg.length_code));
			end else begin
				send_byte(other_byte(cur_cfg.second_header));
			end
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(other_byte(cur_cfg.first_header));
		end
		// Now and then the source waits for the whole result backlog.
		if ($urandom_range(7) == 0) drain_block();
	endtask

	initial begin
		int phase_start;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cur_cfg       = '0;
		sent_items    = 0;
		send_idle_pct = 12;
		recv_idle_pct = 78;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames with the reset headers of all zeros: an all-zero
		// frame whose checksum is zero, an all-ones frame that carries every
		// field at its maximum, and a frame with a corrupted checksum.
		send_frame(FILL_ZERO, 1'b1);
		send_frame(FILL_ONES, 1'b1);
		send_frame(FILL_RANDOM, 1'b0);

		// Distinct header bytes so the fixed-byte mismatch cases can be told
		// apart. A wrong second byte that equals the first header byte must
		// not be taken as the start of a new frame.
		set_config(8'h5A, 8'hA5, 8'h3C);
		send_byte(cur_cfg.first_header);
		send_byte(cur_cfg.first_header);
		send_byte(cur_cfg.second_header);
		send_byte(cur_cfg.first_header);
		send_byte(cur_cfg.second_header);
		send_byte(~cur_cfg.length_code);
		send_byte(8'h00);
		send_frame(FILL_RANDOM, 1'b1);

		// Three random phases with different headers and back-pressure: a
		// slow sink first, then a slow source, then both at full rate.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				set_config(8'hFF, 8'hFF, 8'hFF);
			end else begin
				set_config(8'($urandom()), 8'($urandom()), 8'($urandom()));
			end
			send_idle_pct = (phase == 1) ? 78 : (phase == 0) ? 12 : 0;
			recv_idle_pct = (phase == 1) ? 12 : (phase == 0) ? 78 : 0;
			phase_start   = sent_items;
			while (sent_items - phase_start < PHASE_ITEMS) random_segment();
		end

		drain_block();
		if (fail_count == 0 && points_due == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/lfp_pkg.sv
rtl/lfp_regs.sv
rtl/lfp_dp.sv
rtl/lfp_ctrl.sv
rtl/lidar_frame_parser.sv
dv/lidar_frame_parser_checker.sv
dv/lidar_frame_parser_tb.sv
